// ===== hw/rtl/scbp_pkg.sv =====
package scbp_pkg;

  localparam int NumClasses    = 5;
  localparam int SlotsPerClass = 4;
  localparam int CountClamp    = 4;
  localparam int ClassW        = 3;
  localparam int SlotW         = 2;
  localparam int HandleW       = ClassW + SlotW;
  localparam int LimitW        = 16;
  localparam int CountFieldW   = 3;
  localparam int CountsW       = 15;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 16;

  localparam logic [CfgIdxW-1:0] CfgIdxLimit0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxLimit4 = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxCounts = 3'd5;

  localparam logic [NumClasses-1:0][LimitW-1:0] LimitReset = '{
    16'd50, 16'd70, 16'd100, 16'd50, 16'd20
  };
  localparam logic [CountsW-1:0] CountsReset = 15'd17489;

  typedef enum logic {
    ActAlloc = 1'b0,
    ActFree  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StNoBuf       = 2'd1,
    StAlreadyFree = 2'd2,
    StBadHandle   = 2'd3
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [LimitW-1:0]   req_size;
    logic [HandleW-1:0]  free_handle;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [HandleW-1:0]  granted_handle;
  } out_item_t;

  typedef struct packed {
    logic [NumClasses-1:0][LimitW-1:0] class_limit;
    logic [CountsW-1:0]                class_counts;
  } cfg_t;

  function automatic logic [CountFieldW-1:0] slot_count(
    input logic [CountsW-1:0] counts,
    input logic [ClassW-1:0]  k
  );
    logic [CountFieldW-1:0] n;
    n = counts[int'(k) * CountFieldW +: CountFieldW];
    if (n > CountFieldW'(CountClamp)) n = CountFieldW'(CountClamp);
    if (n > CountFieldW'(SlotsPerClass)) n = CountFieldW'(SlotsPerClass);
    return n;
  endfunction

  function automatic logic [SlotsPerClass-1:0] slot_mask(input logic [CountFieldW-1:0] n);
    logic [SlotsPerClass-1:0] m;
    for (int s = 0; s < SlotsPerClass; s++) begin
      m[s] = CountFieldW'(s) < n;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/scbp_cfg_regs.sv =====
module scbp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scbp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output scbp_pkg::cfg_t                 cfg_o
);

  scbp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_limit  <= scbp_pkg::LimitReset;
      cfg_q.class_counts <= scbp_pkg::CountsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        [scbp_pkg::CfgIdxLimit0:scbp_pkg::CfgIdxLimit4]: begin
          cfg_q.class_limit[cfg_idx_i] <= cfg_wdata_i[scbp_pkg::LimitW-1:0];
        end
        scbp_pkg::CfgIdxCounts: begin
          cfg_q.class_counts <= cfg_wdata_i[scbp_pkg::CountsW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/scbp_engine.sv =====
module scbp_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scbp_pkg::cfg_t       cfg_i,
  input  scbp_pkg::in_item_t   item_i,
  input  logic                 fire_i,
  output scbp_pkg::out_item_t  res_o
);

  logic [scbp_pkg::NumClasses-1:0][scbp_pkg::SlotsPerClass-1:0] free_q, free_d, vis;
  logic                              fit_any;
  logic                              found;
  logic [scbp_pkg::ClassW-1:0]       first;
  logic [scbp_pkg::ClassW-1:0]       hc;
  logic [scbp_pkg::SlotW-1:0]        hs;
  scbp_pkg::out_item_t               res;

  assign hc = item_i.free_handle[scbp_pkg::HandleW-1:scbp_pkg::SlotW];
  assign hs = item_i.free_handle[scbp_pkg::SlotW-1:0];

  always_comb begin
    res                = '0;
    res.status         = scbp_pkg::StNoBuf;
    free_d             = free_q;
    fit_any            = 1'b0;
    first              = '0;
    found              = 1'b0;
    for (int k = 0; k < scbp_pkg::NumClasses; k++) begin
      vis[k] = free_q[k] & scbp_pkg::slot_mask(
                 scbp_pkg::slot_count(cfg_i.class_counts, scbp_pkg::ClassW'(k)));
    end
    for (int k = 0; k < scbp_pkg::NumClasses; k++) begin
      if (!fit_any && (item_i.req_size <= cfg_i.class_limit[k])) begin
        fit_any = 1'b1;
        first   = scbp_pkg::ClassW'(k);
      end
    end
    if (item_i.action == scbp_pkg::ActAlloc) begin
      if (fit_any) begin
        for (int c = 0; c < scbp_pkg::NumClasses; c++) begin
          for (int s = 0; s < scbp_pkg::SlotsPerClass; s++) begin
            if (!found && (scbp_pkg::ClassW'(c) >= first) && vis[c][s]) begin
              found              = 1'b1;
              res.status         = scbp_pkg::StOk;
              res.granted_handle = {scbp_pkg::ClassW'(c), scbp_pkg::SlotW'(s)};
              free_d[c][s]       = 1'b0;
            end
          end
        end
      end
    end else begin
      if (hc >= scbp_pkg::ClassW'(scbp_pkg::NumClasses)) begin
        res.status = scbp_pkg::StBadHandle;
      end else if ({1'b0, hs} >= scbp_pkg::slot_count(cfg_i.class_counts, hc)) begin
        res.status = scbp_pkg::StBadHandle;
      end else if (free_q[hc][hs]) begin
        res.status = scbp_pkg::StAlreadyFree;
      end else begin
        res.status     = scbp_pkg::StOk;
        free_d[hc][hs] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else if (fire_i) begin
      free_q <= free_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hw/rtl/size_class_buffer_pool_unit.sv =====
// A request beat is captured in the input register, and its result is then registered in the
// result register on out_valid_o, delayed while out_ready_i holds off the previous result.
// Throughput: one request per cycle unless out_ready_i stalls a result beat, set by the single
// pass from the input register through class match and slot priority encode to the result register.
// Reset (rst_ni low, asynchronous): pipeline empty, all slots free, class limits
// 20/50/100/70/50 and class counts 1/2/1/2/4.
module size_class_buffer_pool_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scbp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  scbp_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output scbp_pkg::out_item_t            out_item_o
);

  scbp_pkg::cfg_t      cfg;
  scbp_pkg::in_item_t  in_q;
  scbp_pkg::out_item_t res, out_q;
  logic                in_vld_q, out_vld_q;
  logic                advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  scbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scbp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_q),
    .fire_i (advance),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (advance) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/scbp_checker.sv =====
module scbp_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input scbp_pkg::out_item_t  out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat dropped or changed while stalled");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request side stalled without result backpressure");

  a_grant_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != scbp_pkg::StOk |-> out_item_o.granted_handle == '0)
    else $error("nonzero handle on failed request");

  a_grant_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == scbp_pkg::StOk |->
      out_item_o.granted_handle[scbp_pkg::HandleW-1:scbp_pkg::SlotW] <
      scbp_pkg::ClassW'(scbp_pkg::NumClasses))
    else $error("handle outside the pool");

endmodule

bind size_class_buffer_pool_unit scbp_checker u_scbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
